// ===== sv/vtp_pkg.sv =====
package vtp_pkg;

  typedef enum logic [3:0] {
    MODE_WHITE   = 4'd0,
    MODE_RED     = 4'd1,
    MODE_GREEN   = 4'd2,
    MODE_BLUE    = 4'd3,
    MODE_GRAY    = 4'd4,
    MODE_RRAMP   = 4'd5,
    MODE_GRAMP   = 4'd6,
    MODE_BRAMP   = 4'd7,
    MODE_BARS    = 4'd8,
    MODE_CHECKER = 4'd9,
    MODE_GRID    = 4'd10,
    MODE_CROSS   = 4'd11
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_SQUARE = 3'd3,
    REG_RED    = 3'd4,
    REG_GREEN  = 3'd5,
    REG_BLUE   = 3'd6
  } reg_index_t;

  localparam int CoordW   = 12;
  localparam int DimW     = 13;
  localparam int MaxDim   = 4096;
  localparam int QuotW    = 12;
  localparam int QueueDepth = 4;
  localparam int QueueIdxW  = 2;

  // divider sizes: numerator bits and divisor bits
  localparam int DivNumW = 21;
  localparam int DivDenW = 13;

  // divider stages plus the packing register
  localparam int PipeLat = 22;

  // output queue
  localparam int OutDepth = 32;
  localparam int OutIdxW  = 5;

  // per-item work handed from the front end to the pipeline
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } item_t;

  // snapshot of the configuration
  typedef struct packed {
    logic [3:0]      mode;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [11:0]     square;
    logic [8:0]      red_layout;
    logic [8:0]      green_layout;
    logic [8:0]      blue_layout;
  } cfg_t;

  // bars colors packed as {r,g,b} on/off bits
  function automatic logic [2:0] bar_rgb(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      3'd0:    c = 3'b111;
      3'd1:    c = 3'b110;
      3'd2:    c = 3'b011;
      3'd3:    c = 3'b010;
      3'd4:    c = 3'b101;
      3'd5:    c = 3'b100;
      3'd6:    c = 3'b001;
      default: c = 3'b000;
    endcase
    return c;
  endfunction

  // cut an 8-bit channel to its length and place it at its offset
  function automatic logic [31:0] place_channel(input logic [8:0] layout,
                                                input logic [7:0] c);
    logic [4:0]  off;
    logic [3:0]  len;
    logic [7:0]  v;
    logic [63:0] wide;
    off = layout[4:0];
    len = (layout[8:5] > 4'd8) ? 4'd8 : layout[8:5];
    v = (len == 4'd0) ? 8'd0 : (c >> (4'd8 - len));
    wide = {56'd0, v} << off;
    return wide[31:0];
  endfunction

endpackage

// ===== sv/video_test_pattern_pixel.sv =====
// channel   dir  handshake        payload
// input     in   push / full      pixel_x, pixel_y
// result    out  pop / empty      pixel_word, mode_error
// config    in   cfg_valid/ready  cfg_index, cfg_data
// one pixel per clock sustained while pop keeps the output queue from filling; items pass
// through the queue, the 21-stage divider pipeline and the packing register.
// items issue into the pipeline only while the output queue has a slot
// reserved for each one in flight; a stalled pop fills the output queue,
// then the input queue, then full rises.
// rst is synchronous and restores the register defaults.
module video_test_pattern_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] pixel_word,
  output logic        mode_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  vtp_pkg::cfg_t  cfg;
  vtp_pkg::item_t in_item, q_item;
  logic q_empty, q_rd, pipe_valid;
  logic [31:0] pipe_word;
  logic pipe_err;

  assign cfg_ready = 1'b1;
  assign in_item   = '{x: pixel_x, y: pixel_y};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{mode: vtp_pkg::MODE_WHITE, width: 13'd320, height: 13'd240,
               square: 12'd40, red_layout: 9'd171, green_layout: 9'd197,
               blue_layout: 9'd160};
    end else if (cfg_valid) begin
      case (vtp_pkg::reg_index_t'(cfg_index))
        vtp_pkg::REG_MODE:   cfg.mode <= cfg_data[3:0];
        vtp_pkg::REG_WIDTH:  cfg.width <= cfg_data;
        vtp_pkg::REG_HEIGHT: cfg.height <= cfg_data;
        vtp_pkg::REG_SQUARE: cfg.square <= cfg_data[11:0];
        vtp_pkg::REG_RED:    cfg.red_layout <= cfg_data[8:0];
        vtp_pkg::REG_GREEN:  cfg.green_layout <= cfg_data[8:0];
        vtp_pkg::REG_BLUE:   cfg.blue_layout <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // front end queue
  vtp_queue u_queue (.clk, .rst, .wr_en(push), .wr_data(in_item), .full,
                     .rd_en(q_rd), .rd_data(q_item), .empty(q_empty));

  // output queue and credit count for items in flight
  logic [31:0] oword [vtp_pkg::OutDepth];
  logic        oerr  [vtp_pkg::OutDepth];
  logic [vtp_pkg::OutIdxW-1:0] owp, orp;
  logic [vtp_pkg::OutIdxW:0]   ocount, inflight;
  logic pipe_en, out_pop;

  // the pipeline always advances; issue only with a free slot reserved
  assign pipe_en = 1'b1;
  assign q_rd    = !q_empty && ((ocount + inflight) < 6'(vtp_pkg::OutDepth));
  assign out_pop = pop && !empty;

  vtp_pipe u_pipe (.clk, .rst, .en(pipe_en), .in_valid(q_rd), .in_item(q_item),
                   .cfg, .out_valid(pipe_valid), .out_word(pipe_word),
                   .out_error(pipe_err));

  always_ff @(posedge clk) begin
    if (pipe_valid) begin
      oword[owp] <= pipe_word;
      oerr[owp]  <= pipe_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= '0;
      orp <= '0;
      ocount <= '0;
      inflight <= '0;
    end else begin
      if (pipe_valid) owp <= owp + 1'b1;
      if (out_pop) orp <= orp + 1'b1;
      ocount <= ocount + 6'(pipe_valid) - 6'(out_pop);
      inflight <= inflight + 6'(q_rd) - 6'(pipe_valid);
    end
  end

  assign empty      = (ocount == '0);
  assign pixel_word = oword[orp];
  assign mode_error = oerr[orp];

  a_credit: assert property (@(posedge clk) disable iff (rst)
    (ocount + inflight) <= 6'(vtp_pkg::OutDepth)) else $error("output queue overrun");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pipe_valid |-> (inflight != '0)) else $error("result without issue");
  a_err_black: assert property (@(posedge clk) disable iff (rst)
    (!empty && mode_error) |-> (pixel_word == '0)) else $error("error not black");

endmodule

// ===== sv/vtp_queue.sv =====
// small item queue between the front end and the pipeline
module vtp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  vtp_pkg::item_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output vtp_pkg::item_t  rd_data,
  output logic            empty
);

  vtp_pkg::item_t mem [vtp_pkg::QueueDepth];
  logic [vtp_pkg::QueueIdxW-1:0] wr_ptr;
  logic [vtp_pkg::QueueIdxW-1:0] rd_ptr;
  logic [vtp_pkg::QueueIdxW:0]   count;

  assign full    = (count == 3'(vtp_pkg::QueueDepth));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 3'(wr_en && !full) - 3'(rd_en && !empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(vtp_pkg::QueueDepth)) else $error("queue count overflow");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !full && !(rd_en && !empty)) |=> (count == $past(count) + 3'd1))
    else $error("queue count did not rise");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (rd_en && !empty && !(wr_en && !full)) |=> (count == $past(count) - 3'd1))
    else $error("queue count did not fall");

endmodule

// ===== sv/vtp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with remainder
module vtp_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vtp_pkg::DivNumW-1:0] dividend,
  input  logic [vtp_pkg::DivDenW-1:0] divisor,
  output logic [vtp_pkg::DivNumW-1:0] quotient,
  output logic [vtp_pkg::DivDenW-1:0] remainder
);

  logic [vtp_pkg::DivNumW-1:0] q_s [vtp_pkg::DivNumW+1];
  logic [vtp_pkg::DivDenW:0]   r_s [vtp_pkg::DivNumW+1];
  logic [vtp_pkg::DivNumW-1:0] n_s [vtp_pkg::DivNumW+1];
  logic [vtp_pkg::DivDenW-1:0] d_s [vtp_pkg::DivNumW+1];

  always_comb begin
    q_s[0] = '0;
    r_s[0] = '0;
    n_s[0] = dividend;
    d_s[0] = divisor;
  end

  // one stage per quotient bit, registered
  for (genvar i = 0; i < vtp_pkg::DivNumW; i++) begin : g_stage
    logic [vtp_pkg::DivDenW+1:0] trial;
    logic [vtp_pkg::DivDenW+1:0] shifted;
    assign shifted = {r_s[i], n_s[i][vtp_pkg::DivNumW-1]};
    assign trial   = shifted - {2'b00, d_s[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[i+1] <= n_s[i] << 1;
        d_s[i+1] <= d_s[i];
        if (!trial[vtp_pkg::DivDenW+1]) begin
          r_s[i+1] <= trial[vtp_pkg::DivDenW:0];
          q_s[i+1] <= {q_s[i][vtp_pkg::DivNumW-2:0], 1'b1};
        end else begin
          r_s[i+1] <= shifted[vtp_pkg::DivDenW:0];
          q_s[i+1] <= {q_s[i][vtp_pkg::DivNumW-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient  = q_s[vtp_pkg::DivNumW];
  assign remainder = r_s[vtp_pkg::DivNumW][vtp_pkg::DivDenW-1:0];

endmodule

// ===== sv/vtp_pipe.sv =====
// back end: divider pipeline, pattern selection, channel packing
module vtp_pipe (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  vtp_pkg::item_t in_item,
  input  vtp_pkg::cfg_t  cfg,
  output logic           out_valid,
  output logic [31:0]    out_word,
  output logic           out_error
);

  logic [12:0] w, h, s, lastx;
  logic [20:0] ramp_q, bar_q, xs_q, ys_q;
  logic [12:0] xs_r, ys_r;
  logic        v_d [vtp_pkg::PipeLat+1];
  vtp_pkg::item_t it_d [vtp_pkg::PipeLat+1];

  // clamp the frame sizes and square size
  always_comb begin
    w = (cfg.width  > 13'(vtp_pkg::MaxDim)) ? 13'(vtp_pkg::MaxDim) : cfg.width;
    h = (cfg.height > 13'(vtp_pkg::MaxDim)) ? 13'(vtp_pkg::MaxDim) : cfg.height;
    s = (cfg.square == '0) ? 13'd1 : {1'b0, cfg.square};
    lastx = (w > 13'd1) ? w - 13'd1 : 13'd1;
  end

  logic [20:0] x255, x8;
  assign x255 = ({9'd0, in_item.x} << 8) - {9'd0, in_item.x};
  assign x8   = {6'd0, in_item.x, 3'd0};

  vtp_div u_ramp (.clk, .en, .dividend(x255), .divisor(lastx),
                  .quotient(ramp_q), .remainder());
  vtp_div u_bar  (.clk, .en, .dividend(x8), .divisor((w == '0) ? 13'd1 : w),
                  .quotient(bar_q), .remainder());
  vtp_div u_xs   (.clk, .en, .dividend({9'd0, in_item.x}), .divisor(s),
                  .quotient(xs_q), .remainder(xs_r));
  vtp_div u_ys   (.clk, .en, .dividend({9'd0, in_item.y}), .divisor(s),
                  .quotient(ys_q), .remainder(ys_r));

  assign v_d[0]  = in_valid;
  assign it_d[0] = in_item;

  // delay line matching the divider latency plus the packing stage
  for (genvar i = 0; i < vtp_pkg::PipeLat; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) v_d[i+1] <= 1'b0;
      else if (en) v_d[i+1] <= v_d[i];
    end
    always_ff @(posedge clk) begin
      if (en) it_d[i+1] <= it_d[i];
    end
  end

  // pattern channels after the divider
  logic [7:0]  ramp, r, g, b;
  logic [2:0]  bidx, bc;
  logic        on, err;
  logic [11:0] px, py;
  logic [12:0] xp2, yp2;
  always_comb begin
    px = it_d[vtp_pkg::PipeLat-1].x;
    py = it_d[vtp_pkg::PipeLat-1].y;
    xp2 = {1'b0, px} + 13'd2;
    yp2 = {1'b0, py} + 13'd2;
    ramp = (ramp_q > 21'd255) ? 8'd255 : ramp_q[7:0];
    bidx = (w == '0 || bar_q > 21'd7) ? 3'd7 : bar_q[2:0];
    bc = vtp_pkg::bar_rgb(bidx);
    r = '0; g = '0; b = '0; on = 1'b0; err = 1'b0;
    case (vtp_pkg::mode_t'(cfg.mode))
      vtp_pkg::MODE_WHITE:   begin r = 8'hFF; g = 8'hFF; b = 8'hFF; end
      vtp_pkg::MODE_RED:     r = 8'hFF;
      vtp_pkg::MODE_GREEN:   g = 8'hFF;
      vtp_pkg::MODE_BLUE:    b = 8'hFF;
      vtp_pkg::MODE_GRAY:    begin r = ramp; g = ramp; b = ramp; end
      vtp_pkg::MODE_RRAMP:   r = ramp;
      vtp_pkg::MODE_GRAMP:   g = ramp;
      vtp_pkg::MODE_BRAMP:   b = ramp;
      vtp_pkg::MODE_BARS:    begin r = {8{bc[2]}}; g = {8{bc[1]}}; b = {8{bc[0]}}; end
      vtp_pkg::MODE_CHECKER: on = xs_q[0] ^ ys_q[0];
      vtp_pkg::MODE_GRID:    on = (xs_r == '0) || (ys_r == '0);
      vtp_pkg::MODE_CROSS:   on = (px < 12'd2) || (xp2 >= w) || (py < 12'd2) ||
                                  (yp2 >= h) || ({1'b0, px} == (w >> 1)) ||
                                  ({1'b0, py} == (h >> 1));
      default:               err = 1'b1;
    endcase
    if (on) begin
      r = 8'hFF; g = 8'hFF; b = 8'hFF;
    end
  end

  // pack and register the result
  always_ff @(posedge clk) begin
    if (en) begin
      out_error <= err;
      out_word  <= err ? 32'd0 :
                   (vtp_pkg::place_channel(cfg.red_layout, r) |
                    vtp_pkg::place_channel(cfg.green_layout, g) |
                    vtp_pkg::place_channel(cfg.blue_layout, b));
    end
  end

  assign out_valid = v_d[vtp_pkg::PipeLat];

endmodule
